[rtl/vvdc_pkg.sv]
package vvdc_pkg;

    // Sensor sample width and derived full scale
    localparam int SAMPLE_BITS = 12;
    localparam longint FULL_SCALE = (longint'(1) << SAMPLE_BITS) - 1;

    // Pressure conversion: mbar = -sample * PRES_MUL / PRES_DIV
    localparam longint PRES_MUL = 33000;
    localparam longint PRES_DIV = FULL_SCALE * 27;

    // Reciprocal for the truncating divide, exact for every sample value
    localparam int     PRES_SHIFT = 2 * SAMPLE_BITS + 5;
    localparam longint PRES_RECIP =
        ((longint'(1) << PRES_SHIFT) * PRES_MUL + PRES_DIV - 1) / PRES_DIV;
    localparam int     PROD_W = SAMPLE_BITS + PRES_SHIFT;

    // Field and register widths
    localparam int PRES_W   = 12;
    localparam int TARGET_W = 12;
    localparam int THR_W    = TARGET_W + 1;
    localparam int DELTA_W  = 6;
    localparam int BAND_W   = 8;
    localparam int TICKS_W  = 16;
    localparam int PHASE_W  = TICKS_W + 1;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 2;

    // Compare width: sample * PRES_MUL and threshold * PRES_DIV both fit
    localparam int CMP_W = SAMPLE_BITS + 17;

    // Target limits and reset value
    localparam int TARGET_MIN   = -1250;
    localparam int TARGET_MAX   = 250;
    localparam int TARGET_RESET = -200;

    // Register reset values
    localparam int BAND_RESET    = 5;
    localparam int SUCTION_RESET = 2000;
    localparam int RELEASE_RESET = 1000;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_BAND     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SUCTION_TICKS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_TICKS = 2'd2;

    // Input word command
    typedef enum logic {
        CMD_TICK  = 1'b0,
        CMD_NUDGE = 1'b1
    } t_cmd;

    // Valve regulation mode
    typedef enum logic [1:0] {
        MODE_INITIAL   = 2'd0,
        MODE_SUCKING   = 2'd1,
        MODE_RELEASING = 2'd2,
        MODE_HOLDING   = 2'd3
    } t_mode;

    // Valve levels: suction in bit 0, release in bit 1
    typedef struct packed {
        logic release_high;
        logic suction_high;
    } t_valves;

endpackage

[rtl/vacuum_valve_deadband_controller.sv]
// Vacuum valve deadband controller.
// Input channel (i_in_valid / o_in_stall) carries one word per tick or nudge:
// i_command selects a timer tick with i_adc_sample or a target nudge by
// i_target_delta. Output channel (o_out_valid / i_out_stall) returns exactly
// one result word per input word: valve levels, mode, suction window flag,
// last pressure in mbar and current target in mbar.
// Configuration is written through i_cfg_we / i_cfg_index / i_cfg_data; the
// user must write it only while the block is idle, as the block itself does
// not enforce this. Indexes are hold band, suction ticks, release ticks.
// A word accepted into the input register has its result loaded into the
// output register as soon as that register is free or drains.
// Throughput: one word per cycle unless the receiver stalls. The mode and
// target feedback through one pass of compare logic per cycle sets this
// figure.
// Reset (synchronous, active low) clears both pipeline registers, restores
// the register defaults, the target of -200 mbar and the initial mode.
// When the receiver stalls, the result word holds and the input register
// keeps its word; o_in_stall rises only while both registers are full.
module vacuum_valve_deadband_controller
    import vvdc_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_command,
    input  logic [SAMPLE_BITS-1:0]      i_adc_sample,
    input  logic signed [DELTA_W-1:0]   i_target_delta,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_suction_valve_high,
    output logic                        o_release_valve_high,
    output logic [1:0]                  o_valve_mode,
    output logic                        o_suction_window,
    output logic signed [PRES_W-1:0]    o_pressure_mbar,
    output logic signed [TARGET_W-1:0]  o_target_mbar,
    input  logic                        i_cfg_we,
    input  logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [CFG_W-1:0]            i_cfg_data
);

    // Configuration registers
    logic [BAND_W-1:0]  r_hold_band;
    logic [TICKS_W-1:0] r_suction_ticks;
    logic [TICKS_W-1:0] r_release_ticks;

    // Input register
    logic                       r_in_valid;
    t_cmd                       r_command;
    logic [SAMPLE_BITS-1:0]     r_sample;
    logic signed [DELTA_W-1:0]  r_delta;

    // Controller state
    logic [PHASE_W-1:0]         r_phase;
    t_mode                      r_mode;
    logic signed [TARGET_W-1:0] r_target;
    t_valves                    r_valves;
    logic signed [PRES_W-1:0]   r_pressure;

    // Output register
    logic                       r_out_valid;
    t_valves                    r_out_valves;
    t_mode                      r_out_mode;
    logic                       r_out_window;
    logic signed [PRES_W-1:0]   r_out_pressure;
    logic signed [TARGET_W-1:0] r_out_target;

    // Next values
    logic [PHASE_W-1:0]         n_phase;
    t_mode                      n_mode;
    logic signed [TARGET_W-1:0] n_target;
    t_valves                    n_valves;
    logic signed [PRES_W-1:0]   n_pressure;
    logic                       n_window;

    // Datapath intermediates
    logic                       advance;
    logic                       fire;
    logic                       in_accept;
    logic [PHASE_W-1:0]         period;
    logic [PHASE_W:0]           phase_inc;
    logic [PHASE_W-1:0]         tick_phase;
    logic signed [THR_W-1:0]    nudge_sum;
    logic signed [THR_W-1:0]    band_ext;
    logic signed [THR_W-1:0]    neg_hi;
    logic signed [THR_W-1:0]    neg_lo;
    logic signed [CMP_W-1:0]    lhs;
    logic signed [CMP_W-1:0]    rhs_hi;
    logic signed [CMP_W-1:0]    rhs_lo;
    logic [PROD_W-1:0]          pres_prod;

    // Pipeline handshake: advance when the output register is free or drains
    assign advance    = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && advance;
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    // Phase counter wrap
    assign period     = PHASE_W'(r_suction_ticks) + PHASE_W'(r_release_ticks);
    assign phase_inc  = (PHASE_W+1)'(r_phase) + (PHASE_W+1)'(1);
    assign tick_phase = (phase_inc >= (PHASE_W+1)'(period)) ? '0 : r_phase + PHASE_W'(1);

    // Saturating target nudge
    assign nudge_sum = THR_W'(r_target) + THR_W'(r_delta);

    // Deadband thresholds, negated so both compare sides are scaled integers
    assign band_ext = $signed(THR_W'(r_hold_band));
    assign neg_hi   = -(THR_W'(r_target) + band_ext);
    assign neg_lo   = -(THR_W'(r_target) - band_ext);
    assign lhs      = $signed(CMP_W'(r_sample) * CMP_W'(PRES_MUL));
    assign rhs_hi   = CMP_W'(neg_hi) * CMP_W'(PRES_DIV);
    assign rhs_lo   = CMP_W'(neg_lo) * CMP_W'(PRES_DIV);

    // Pressure magnitude by reciprocal multiply, truncated toward zero
    assign pres_prod = PROD_W'(r_sample) * PROD_W'(PRES_RECIP);

    // Next state and result for the word in the input register
    always_comb begin
        n_phase    = r_phase;
        n_mode     = r_mode;
        n_target   = r_target;
        n_valves   = r_valves;
        n_pressure = r_pressure;
        n_window   = 1'b0;
        unique case (r_command)
            CMD_NUDGE: begin
                n_mode = MODE_INITIAL;
                if (nudge_sum < THR_W'(TARGET_MIN)) begin
                    n_target = TARGET_W'(TARGET_MIN);
                end else if (nudge_sum > THR_W'(TARGET_MAX)) begin
                    n_target = TARGET_W'(TARGET_MAX);
                end else begin
                    n_target = TARGET_W'(nudge_sum);
                end
                n_window = (r_phase < PHASE_W'(r_suction_ticks));
            end
            CMD_TICK: begin
                n_phase    = tick_phase;
                n_window   = (tick_phase < PHASE_W'(r_suction_ticks));
                n_pressure = -$signed(pres_prod[PRES_SHIFT +: PRES_W]);
                if (n_window) begin
                    priority if (lhs <= rhs_hi) begin
                        n_mode   = MODE_SUCKING;
                        n_valves = '{release_high: 1'b0, suction_high: 1'b0};
                    end else if (lhs <= rhs_lo || r_mode == MODE_SUCKING
                                 || r_mode == MODE_HOLDING) begin
                        n_mode   = MODE_HOLDING;
                        n_valves = '{release_high: 1'b0, suction_high: 1'b1};
                    end else begin
                        n_mode   = MODE_RELEASING;
                        n_valves = '{release_high: 1'b1, suction_high: 1'b1};
                    end
                end else begin
                    n_valves = '{release_high: 1'b1, suction_high: 1'b1};
                end
            end
            default: begin
                n_mode = r_mode;
            end
        endcase
    end

    // Control, configuration and controller state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid      <= 1'b0;
            r_out_valid     <= 1'b0;
            r_hold_band     <= BAND_W'(BAND_RESET);
            r_suction_ticks <= TICKS_W'(SUCTION_RESET);
            r_release_ticks <= TICKS_W'(RELEASE_RESET);
            r_phase         <= '0;
            r_mode          <= MODE_INITIAL;
            r_target        <= TARGET_W'(TARGET_RESET);
            r_valves        <= '{release_high: 1'b0, suction_high: 1'b0};
            r_pressure      <= '0;
        end else begin
            // Hold or refill the input register
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            // Load or drain the output register
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            // Advance controller state
            if (fire) begin
                r_phase    <= n_phase;
                r_mode     <= n_mode;
                r_target   <= n_target;
                r_valves   <= n_valves;
                r_pressure <= n_pressure;
            end
            // Register writes
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_HOLD_BAND:     r_hold_band     <= i_cfg_data[BAND_W-1:0];
                    CFG_SUCTION_TICKS: r_suction_ticks <= i_cfg_data[TICKS_W-1:0];
                    CFG_RELEASE_TICKS: r_release_ticks <= i_cfg_data[TICKS_W-1:0];
                    default:           r_hold_band     <= r_hold_band;
                endcase
            end
        end
    end

    // Capture input word and result word payloads
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_command <= t_cmd'(i_command);
            r_sample  <= i_adc_sample;
            r_delta   <= i_target_delta;
        end
        if (fire) begin
            r_out_valves   <= n_valves;
            r_out_mode     <= n_mode;
            r_out_window   <= n_window;
            r_out_pressure <= n_pressure;
            r_out_target   <= n_target;
        end
    end

    // Drive result ports
    assign o_out_valid          = r_out_valid;
    assign o_suction_valve_high = r_out_valves.suction_high;
    assign o_release_valve_high = r_out_valves.release_high;
    assign o_valve_mode         = r_out_mode;
    assign o_suction_window     = r_out_window;
    assign o_pressure_mbar      = r_out_pressure;
    assign o_target_mbar        = r_out_target;

`ifndef SYNTHESIS
    // Target never leaves its saturation range
    a_target_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_target >= TARGET_W'(TARGET_MIN) && r_target <= TARGET_W'(TARGET_MAX))
        else $error("target out of range");

    // Input side stalls only while the output word is held by the receiver
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_out_valid && i_out_stall)
        else $error("input stalled without a held output word");

    // A nudge returns a result in initial mode
    a_nudge_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && r_command == CMD_NUDGE |=> o_out_valid && o_valve_mode == MODE_INITIAL)
        else $error("nudge result not in initial mode");

    // A tick outside the suction window opens both valves
    a_release_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && r_command == CMD_TICK && !n_window
        |=> o_suction_valve_high && o_release_valve_high && !o_suction_window)
        else $error("valves not released outside suction window");
`endif

endmodule

[test/vacuum_valve_deadband_controller_tb.sv]
import vvdc_pkg::*;

// Predicts the valve result of every accepted word and checks results in order
class valve_scoreboard;

    typedef struct {
        logic                suction_hi;
        logic                release_hi;
        t_mode               mode;
        logic                window;
        logic [PRES_W-1:0]   pressure;
        logic [TARGET_W-1:0] target;
    } t_valve_word;

    t_valve_word expected_q[$];

    // Register copies
    int unsigned band;
    int unsigned suction_len;
    int unsigned release_len;

    // Controller state copies
    int unsigned phase;
    t_mode       mode;
    int          target;
    t_valves     valves;
    int          pressure;

    int errors;
    int mismatches;

    function new();
        band        = BAND_RESET;
        suction_len = SUCTION_RESET;
        release_len = RELEASE_RESET;
        phase       = 0;
        mode        = MODE_INITIAL;
        target      = TARGET_RESET;
        valves      = '0;
        pressure    = 0;
        errors      = 0;
        mismatches  = 0;
    endfunction

    function void set_config(int unsigned band_v, int unsigned suction_v,
                             int unsigned release_v);
        band        = band_v;
        suction_len = suction_v;
        release_len = release_v;
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    // Advance the controller by one accepted word and queue its result
    function void note_word(logic cmd, logic [SAMPLE_BITS-1:0] sample,
                            logic [DELTA_W-1:0] delta);
        t_valve_word w;
        int unsigned period;
        int unsigned nxt;
        longint      scaled;
        longint      hi;
        longint      lo;
        logic        win;
        if (t_cmd'(cmd) == CMD_NUDGE) begin
            target = target + int'($signed(delta));
            if (target < TARGET_MIN) target = TARGET_MIN;
            if (target > TARGET_MAX) target = TARGET_MAX;
            mode = MODE_INITIAL;
            win  = (phase < suction_len);
        end else begin
            period = suction_len + release_len;
            nxt    = phase + 1;
            if (nxt >= period) nxt = 0;
            phase  = nxt;
            win    = (nxt < suction_len);
            scaled   = longint'(sample) * PRES_MUL;
            pressure = -int'(scaled / PRES_DIV);
            if (win) begin
                hi = longint'(target) + longint'(band);
                lo = longint'(target) - longint'(band);
                if (scaled <= -(hi * PRES_DIV)) begin
                    valves = '0;
                    mode   = MODE_SUCKING;
                end else if (scaled <= -(lo * PRES_DIV) || mode == MODE_SUCKING ||
                             mode == MODE_HOLDING) begin
                    valves = '0;
                    valves.suction_high = 1'b1;
                    mode   = MODE_HOLDING;
                end else begin
                    valves = '1;
                    mode   = MODE_RELEASING;
                end
            end else begin
                valves = '1;
            end
        end
        w.suction_hi = valves.suction_high;
        w.release_hi = valves.release_high;
        w.mode       = mode;
        w.window     = win;
        w.pressure   = pressure[PRES_W-1:0];
        w.target     = target[TARGET_W-1:0];
        expected_q.push_back(w);
    endfunction

    // Compare one result word against the oldest prediction
    function void check_word(logic suc, logic rel, logic [1:0] md, logic win,
                             logic [PRES_W-1:0] pres, logic [TARGET_W-1:0] tgt);
        t_valve_word w;
        if (expected_q.size() == 0) begin
            errors++;
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result word: suc=%0d rel=%0d mode=%0d win=%0d p=%0d t=%0d",
                         suc, rel, md, win, $signed(pres), $signed(tgt));
            return;
        end
        w = expected_q.pop_front();
        if (suc !== w.suction_hi || rel !== w.release_hi || md !== w.mode ||
            win !== w.window || pres !== w.pressure || tgt !== w.target) begin
            errors++;
            mismatches++;
            if (mismatches <= 10) begin
                $display("mismatch exp: suc=%0d rel=%0d mode=%0d win=%0d p=%0d t=%0d",
                         w.suction_hi, w.release_hi, w.mode, w.window,
                         $signed(w.pressure), $signed(w.target));
                $display("         act: suc=%0d rel=%0d mode=%0d win=%0d p=%0d t=%0d",
                         suc, rel, md, win, $signed(pres), $signed(tgt));
            end
        end
    endfunction

endclass

module vacuum_valve_deadband_controller_tb;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_stall;
    logic                       i_command = 1'b0;
    logic [SAMPLE_BITS-1:0]     i_adc_sample = '0;
    logic signed [DELTA_W-1:0]  i_target_delta = '0;
    logic                       o_out_valid;
    logic                       i_out_stall = 1'b0;
    logic                       o_suction_valve_high;
    logic                       o_release_valve_high;
    logic [1:0]                 o_valve_mode;
    logic                       o_suction_window;
    logic signed [PRES_W-1:0]   o_pressure_mbar;
    logic signed [TARGET_W-1:0] o_target_mbar;
    logic                       i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]       i_cfg_index = '0;
    logic [CFG_W-1:0]           i_cfg_data = '0;

    int send_idle_pct = 0;
    int stall_pct     = 0;

    valve_scoreboard sb = new();

    vacuum_valve_deadband_controller u_top (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_in_valid           (i_in_valid),
        .o_in_stall           (o_in_stall),
        .i_command            (i_command),
        .i_adc_sample         (i_adc_sample),
        .i_target_delta       (i_target_delta),
        .o_out_valid          (o_out_valid),
        .i_out_stall          (i_out_stall),
        .o_suction_valve_high (o_suction_valve_high),
        .o_release_valve_high (o_release_valve_high),
        .o_valve_mode         (o_valve_mode),
        .o_suction_window     (o_suction_window),
        .o_pressure_mbar      (o_pressure_mbar),
        .o_target_mbar        (o_target_mbar),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data)
    );

    // Free-running clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Stall the result channel at random
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Note accepted input words and check accepted result words
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall)
                sb.note_word(i_command, i_adc_sample, i_target_delta);
            if (o_out_valid && !i_out_stall)
                sb.check_word(o_suction_valve_high, o_release_valve_high, o_valve_mode,
                              o_suction_window, o_pressure_mbar, o_target_mbar);
        end
    end

    // Sample for the given mbar level, truncated toward zero from the exact value
    function automatic longint level_sample(longint level);
        return (-level * PRES_DIV) / PRES_MUL;
    endfunction

    // Pick a sample close to the deadband around the current target
    function automatic logic [SAMPLE_BITS-1:0] near_sample(int tgt, int unsigned band);
        longint center;
        longint span;
        longint s;
        center = level_sample(longint'(tgt));
        span   = (longint'(band) * 34) / 10 + 6;
        s      = center - span + longint'($urandom_range(0, int'(2 * span)));
        if (s < 0) s = 0;
        if (s > FULL_SCALE) s = FULL_SCALE;
        return s[SAMPLE_BITS-1:0];
    endfunction

    // Offer one word, possibly after an idle gap, and hold it until accepted
    task automatic send_word(input t_cmd cmd, input logic [SAMPLE_BITS-1:0] sample,
                             input logic [DELTA_W-1:0] delta);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_command      <= cmd;
        i_adc_sample   <= sample;
        i_target_delta <= delta;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // Drop valid and wait until every predicted result has arrived
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Write all registers plus the unused index, then update the predictor
    task automatic program_regs(input int unsigned band, input int unsigned suction_v,
                                input int unsigned release_v);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_HOLD_BAND;
        i_cfg_data  <= {8'($urandom), 8'(band)};
        @(posedge i_clk);
        i_cfg_index <= CFG_SUCTION_TICKS;
        i_cfg_data  <= 16'(suction_v);
        @(posedge i_clk);
        i_cfg_index <= CFG_RELEASE_TICKS;
        i_cfg_data  <= 16'(release_v);
        @(posedge i_clk);
        i_cfg_index <= CFG_SPARE;
        i_cfg_data  <= 16'($urandom);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.set_config(band & 8'hFF, suction_v & 16'hFFFF, release_v & 16'hFFFF);
        @(posedge i_clk);
    endtask

    // Send random words: bias steers nudges up (>0), down (<0) or not at all
    task automatic run_words(input int count, input int nudge_pct, input int bias);
        logic [SAMPLE_BITS-1:0] s;
        logic [DELTA_W-1:0]     d;
        repeat (count) begin
            s = SAMPLE_BITS'($urandom);
            d = DELTA_W'($urandom);
            if ($urandom_range(99) < nudge_pct) begin
                if (bias > 0)
                    d = DELTA_W'($urandom_range(10, 31));
                else if (bias < 0)
                    d = -DELTA_W'($urandom_range(10, 32));
                else if ($urandom_range(99) < 80)
                    d = DELTA_W'($urandom_range(0, 50) - 25);
                send_word(CMD_NUDGE, s, d);
            end else begin
                if ($urandom_range(99) < 70) s = near_sample(sb.target, sb.band);
                send_word(CMD_TICK, s, d);
            end
        end
    endtask

    // Give up after a generous fixed time
    initial begin
        #2000000;
        $display("vacuum_valve_deadband_controller_tb NOT OK");
        $finish;
    end

    initial begin
        longint edge_s;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 32;
        stall_pct     = 75;

        // Directed words on reset registers: band 5, window open
        send_word(CMD_TICK, '0, '0);
        send_word(CMD_TICK, '1, '1);
        send_word(CMD_TICK, '1, '0);
        send_word(CMD_NUDGE, '0, '0);
        send_word(CMD_TICK, '1, '0);
        send_word(CMD_TICK, 12'd2048, '0);
        send_word(CMD_NUDGE, '1, 6'sd31);
        send_word(CMD_NUDGE, '0, -6'sd32);
        send_word(CMD_NUDGE, '0, 6'sd25);
        send_word(CMD_NUDGE, '0, -6'sd25);
        // Target is now -201: probe both edges of the deadband
        edge_s = level_sample(TARGET_RESET - 1 + BAND_RESET);
        send_word(CMD_TICK, edge_s[SAMPLE_BITS-1:0], '0);
        send_word(CMD_TICK, SAMPLE_BITS'(edge_s + 1), '0);
        edge_s = level_sample(TARGET_RESET - 1 - BAND_RESET);
        send_word(CMD_TICK, SAMPLE_BITS'(edge_s + 1), '0);
        send_word(CMD_NUDGE, '0, '0);
        send_word(CMD_TICK, SAMPLE_BITS'(edge_s + 1), '0);
        send_word(CMD_TICK, edge_s[SAMPLE_BITS-1:0], '0);
        drain();

        // Short periods with a hold-off in the middle
        program_regs(5, 12, 4);
        run_words(75, 15, 0);
        drain();
        run_words(75, 15, 0);
        drain();

        // No deadband
        program_regs(0, 7, 3);
        run_words(100, 15, 0);
        drain();

        // Widest deadband, period of one
        program_regs(255, 1, 0);
        run_words(60, 15, 0);
        drain();

        // Window closed for good
        program_regs($urandom_range(0, 255), 0, 5);
        run_words(50, 15, 0);
        drain();

        // Period zero
        program_regs($urandom_range(0, 255), 0, 0);
        run_words(40, 15, 0);
        drain();

        send_idle_pct = 75;
        stall_pct     = 32;

        // Drive the target into both limits
        program_regs(20, 30, 10);
        run_words(100, 60, 1);
        run_words(100, 60, -1);
        drain();

        // Longest window and release
        program_regs($urandom_range(0, 60), 16'hFFFF, 16'hFFFF);
        run_words(100, 10, 0);
        drain();

        // Shrink the period below the stored phase
        program_regs(3, 5, 2);
        run_words(100, 15, 0);
        drain();

        send_idle_pct = 0;
        stall_pct     = 0;

        // Random short settings at full rate
        repeat (3) begin
            program_regs($urandom_range(0, 40), $urandom_range(1, 15), $urandom_range(0, 8));
            run_words(50, 15, 0);
            drain();
        end

        if (sb.errors == 0 && sb.pending() == 0)
            $display("vacuum_valve_deadband_controller_tb OK");
        else
            $display("vacuum_valve_deadband_controller_tb NOT OK");
        $finish;
    end

endmodule

[vacuum_valve_deadband_controller.f]
rtl/vvdc_pkg.sv
rtl/vacuum_valve_deadband_controller.sv
test/vacuum_valve_deadband_controller_tb.sv
